/* src/ctfp_pkg.sv */
// Shared constants and types for the comma-separated three-integer frame parser.
package ctfp_pkg;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [18:0] MAG_LIMIT = 19'd32767;

    localparam logic [15:0] HELD_XY_RESET  = 16'hFC19; // -999, no target
    localparam logic [15:0] HELD_CMD_RESET = 16'hFFFF; // -1, idle

    localparam logic [1:0] FIELD_X    = 2'd0;
    localparam logic [1:0] FIELD_Y    = 2'd1;
    localparam logic [1:0] FIELD_CMD  = 2'd2;
    localparam logic [1:0] FIELD_DONE = 2'd3;

    localparam int unsigned QUEUE_DEPTH = 3;

    typedef struct packed {
        logic               ok;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] cmd;
    } result_t;

endpackage

/* src/ctfp_parser.sv */
// Per-byte field parser: parse state, held registers and the frame result.
module ctfp_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic [7:0]       rx_byte,
    input  logic             last,
    output logic             res_valid,
    output ctfp_pkg::result_t res
);

    logic [1:0]  field_reg,  field_next;
    logic        failed_reg, failed_next;
    logic        sign_reg,   sign_next;
    logic        neg_reg,    neg_next;
    logic        digit_reg,  digit_next;
    logic [15:0] mag_reg,    mag_next;
    logic [15:0] hx_reg,     hx_next;
    logic [15:0] hy_reg,     hy_next;
    logic [15:0] hc_reg,     hc_next;
    logic        ok;

    always_comb
    begin
        logic        is_sign;
        logic        is_term;
        logic        is_digit;
        logic [18:0] acc;
        logic [18:0] limit;
        logic [15:0] value;

        field_next  = field_reg;
        failed_next = failed_reg;
        sign_next   = sign_reg;
        neg_next    = neg_reg;
        digit_next  = digit_reg;
        mag_next    = mag_reg;
        hx_next     = hx_reg;
        hy_next     = hy_reg;
        hc_next     = hc_reg;
        ok          = 1'b0;

        is_sign  = (rx_byte == ctfp_pkg::CHAR_MINUS) || (rx_byte == ctfp_pkg::CHAR_PLUS);
        is_term  = (rx_byte == ctfp_pkg::CHAR_COMMA) || (rx_byte == ctfp_pkg::CHAR_CR)
                || (rx_byte == ctfp_pkg::CHAR_LF);
        is_digit = (rx_byte >= ctfp_pkg::CHAR_ZERO) && (rx_byte <= ctfp_pkg::CHAR_NINE);
        acc      = {mag_reg, 3'b000} + {2'b00, mag_reg, 1'b0}
                 + {11'd0, rx_byte - ctfp_pkg::CHAR_ZERO};
        limit    = ctfp_pkg::MAG_LIMIT + {18'd0, neg_reg};
        value    = neg_reg ? (16'd0 - mag_reg) : mag_reg;

        if (item_valid)
        begin
            if (!failed_reg && (field_reg != ctfp_pkg::FIELD_DONE))
            begin
                priority if (!sign_reg && !digit_reg && is_sign)
                begin
                    sign_next = 1'b1;
                    neg_next  = (rx_byte == ctfp_pkg::CHAR_MINUS);
                end
                else if (is_term)
                begin
                    if (!digit_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        unique case (field_reg)
                            ctfp_pkg::FIELD_X:   hx_next = value;
                            ctfp_pkg::FIELD_Y:   hy_next = value;
                            ctfp_pkg::FIELD_CMD: hc_next = value;
                            default:             ;
                        endcase
                        if (field_reg == ctfp_pkg::FIELD_CMD)
                        begin
                            field_next = ctfp_pkg::FIELD_DONE;
                        end
                        else if (rx_byte == ctfp_pkg::CHAR_COMMA)
                        begin
                            field_next = field_reg + 2'd1;
                            sign_next  = 1'b0;
                            neg_next   = 1'b0;
                            digit_next = 1'b0;
                            mag_next   = '0;
                        end
                        else
                        begin
                            failed_next = 1'b1; // CR/LF where a comma is due
                        end
                    end
                end
                else if (is_digit)
                begin
                    if (acc > limit)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        mag_next   = acc[15:0];
                        digit_next = 1'b1;
                    end
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end

            if (last)
            begin
                // frame end closes an open field that holds a digit
                if (!failed_next)
                begin
                    if (field_next == ctfp_pkg::FIELD_DONE)
                    begin
                        ok = 1'b1;
                    end
                    else if (digit_next)
                    begin
                        value = neg_next ? (16'd0 - mag_next) : mag_next;
                        unique case (field_next)
                            ctfp_pkg::FIELD_X:   hx_next = value;
                            ctfp_pkg::FIELD_Y:   hy_next = value;
                            ctfp_pkg::FIELD_CMD: hc_next = value;
                            default:             ;
                        endcase
                        ok = (field_next == ctfp_pkg::FIELD_CMD);
                    end
                end
                field_next  = ctfp_pkg::FIELD_X;
                failed_next = 1'b0;
                sign_next   = 1'b0;
                neg_next    = 1'b0;
                digit_next  = 1'b0;
                mag_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg  <= ctfp_pkg::FIELD_X;
            failed_reg <= 1'b0;
            sign_reg   <= 1'b0;
            neg_reg    <= 1'b0;
            digit_reg  <= 1'b0;
            mag_reg    <= '0;
            hx_reg     <= ctfp_pkg::HELD_XY_RESET;
            hy_reg     <= ctfp_pkg::HELD_XY_RESET;
            hc_reg     <= ctfp_pkg::HELD_CMD_RESET;
        end
        else
        begin
            field_reg  <= field_next;
            failed_reg <= failed_next;
            sign_reg   <= sign_next;
            neg_reg    <= neg_next;
            digit_reg  <= digit_next;
            mag_reg    <= mag_next;
            hx_reg     <= hx_next;
            hy_reg     <= hy_next;
            hc_reg     <= hc_next;
        end
    end

    assign res_valid = item_valid && last;
    assign res.ok    = ok;
    assign res.x     = hx_next;
    assign res.y     = hy_next;
    assign res.cmd   = hc_next;

    // after a frame end the parse state is back at the start of field x
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && last |=> (field_reg == ctfp_pkg::FIELD_X) && !failed_reg
                               && !digit_reg && !sign_reg && (mag_reg == 16'd0))
        else $error("parse state not cleared after frame end");

    a_mag_limit: assert property (@(posedge clk) disable iff (!rst_n)
        !neg_reg |-> !mag_reg[15])
        else $error("positive magnitude above limit");

    a_digit_mag: assert property (@(posedge clk) disable iff (!rst_n)
        !digit_reg |-> (mag_reg == 16'd0))
        else $error("magnitude set without a digit");

endmodule

/* src/csv_three_int_frame_parser_unit.sv */
// Top level of the comma-separated three-integer frame parser.
// A frame's result passes the input register stage and the result queue.
// Throughput: one byte transaction per cycle; the parse update is a single
// registered pass, and a 3-entry result queue keeps input flowing while a
// result waits downstream. Input stalls only when that queue could overflow.
// Reset (rst_n, async, active low): parse state cleared, queue empty,
// held x/y = -999, held command = -1.
module csv_three_int_frame_parser_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               frame_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               frame_ok,
    output logic signed [15:0] offset_x,
    output logic signed [15:0] offset_y,
    output logic signed [15:0] command_echo
);

    localparam int unsigned QD = ctfp_pkg::QUEUE_DEPTH;
    localparam int unsigned CW = $clog2(QD + 1);

    // input register stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       in_accept;

    // parser result
    logic              push;
    ctfp_pkg::result_t push_res;

    // result queue: entry 0 is the head presented at the output
    ctfp_pkg::result_t q_reg [QD];
    ctfp_pkg::result_t q_next [QD];
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pop;

    assign in_accept = in_valid && !in_stall;

    // Conservative space check: a frame-end byte sitting in the input stage
    // will need one queue entry, and a newly accepted byte might need another.
    assign in_stall = ({1'b0, cnt_reg} + {{CW{1'b0}}, s1_valid_reg && s1_last_reg})
                      >= (CW + 1)'(QD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= rx_byte;
            s1_last_reg <= frame_end;
        end
    end

    ctfp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s1_valid_reg),
        .rx_byte    (s1_byte_reg),
        .last       (s1_last_reg),
        .res_valid  (push),
        .res        (push_res)
    );

    assign pop = (cnt_reg != '0) && !out_stall;

    always_comb
    begin
        logic [CW-1:0] wr_idx;

        wr_idx = cnt_reg - {{(CW-1){1'b0}}, pop};
        for (int i = 0; i < QD; i++)
        begin
            q_next[i] = q_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < QD - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int i = 0; i < QD; i++)
        begin
            if (push && (wr_idx == CW'(i)))
            begin
                q_next[i] = push_res;
            end
        end
        cnt_next = cnt_reg + {{(CW-1){1'b0}}, push} - {{(CW-1){1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QD; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    assign out_valid    = (cnt_reg != '0);
    assign frame_ok     = q_reg[0].ok;
    assign offset_x     = q_reg[0].x;
    assign offset_y     = q_reg[0].y;
    assign command_echo = q_reg[0].cmd;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> (cnt_reg < CW'(QD)))
        else $error("result queue overflow");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QD))
        else $error("result queue count out of range");

    a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && frame_end |=> ##1 (cnt_reg != '0))
        else $error("frame end transaction gave no result");

endmodule

/* tb/tb_csv_three_int_frame_parser_unit.sv */
// Testbench for the three-field CSV frame parser: random and directed frames checked by a scoreboard.

// Scoreboard: mirrors the parse state and the held values, and queues the
// result each completed frame should give.
class frame_result_tracker;
    logic [1:0]        field_idx;
    bit                failed;
    bit                sign_seen;
    bit                neg;
    bit                digit_seen;
    logic [15:0]       mag;
    logic [15:0]       held_x;
    logic [15:0]       held_y;
    logic [15:0]       held_cmd;
    ctfp_pkg::result_t awaited[$];
    int unsigned       mismatches;
    int unsigned       frames_checked;

    function new();
        held_x         = ctfp_pkg::HELD_XY_RESET;
        held_y         = ctfp_pkg::HELD_XY_RESET;
        held_cmd       = ctfp_pkg::HELD_CMD_RESET;
        mismatches     = 0;
        frames_checked = 0;
        restart_frame();
    endfunction

    function void clear_field();
        sign_seen  = 1'b0;
        neg        = 1'b0;
        digit_seen = 1'b0;
        mag        = 16'd0;
    endfunction

    function void restart_frame();
        field_idx = ctfp_pkg::FIELD_X;
        failed    = 1'b0;
        clear_field();
    endfunction

    function void commit_field();
        logic [15:0] v;
        v = neg ? 16'(16'd0 - mag) : mag;
        case (field_idx)
            ctfp_pkg::FIELD_X:   held_x   = v;
            ctfp_pkg::FIELD_Y:   held_y   = v;
            ctfp_pkg::FIELD_CMD: held_cmd = v;
            default:   ;
        endcase
    endfunction

    function void parse_byte(logic [7:0] b);
        int v;
        if (failed || field_idx == ctfp_pkg::FIELD_DONE)
            return;
        if (!sign_seen && !digit_seen
            && (b == ctfp_pkg::CHAR_MINUS || b == ctfp_pkg::CHAR_PLUS))
        begin
            sign_seen = 1'b1;
            neg       = (b == ctfp_pkg::CHAR_MINUS);
        end
        else if (b == ctfp_pkg::CHAR_COMMA || b == ctfp_pkg::CHAR_CR
                 || b == ctfp_pkg::CHAR_LF)
        begin
            if (!digit_seen)
                failed = 1'b1;
            else
            begin
                commit_field();
                if (field_idx == ctfp_pkg::FIELD_CMD)
                    field_idx = ctfp_pkg::FIELD_DONE;
                else if (b == ctfp_pkg::CHAR_COMMA)
                begin
                    field_idx++;
                    clear_field();
                end
                else
                    failed = 1'b1;
            end
        end
        else if (b >= ctfp_pkg::CHAR_ZERO && b <= ctfp_pkg::CHAR_NINE)
        begin
            v = int'(mag) * 10 + int'(b - ctfp_pkg::CHAR_ZERO);
            if (v > int'(ctfp_pkg::MAG_LIMIT) + (neg ? 1 : 0))
                failed = 1'b1;
            else
            begin
                mag        = 16'(v);
                digit_seen = 1'b1;
            end
        end
        else
            failed = 1'b1;
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(logic [7:0] b, logic last);
        ctfp_pkg::result_t want;
        parse_byte(b);
        if (!last)
            return;
        want.ok = 1'b0;
        if (!failed)
        begin
            if (field_idx == ctfp_pkg::FIELD_DONE)
                want.ok = 1'b1;
            else if (digit_seen)
            begin
                commit_field();
                want.ok = (field_idx == ctfp_pkg::FIELD_CMD);
            end
        end
        want.x   = held_x;
        want.y   = held_y;
        want.cmd = held_cmd;
        awaited.push_back(want);
        restart_frame();
    endfunction

    function void match_field(string name, time stamp,
                              logic signed [15:0] want_v, logic signed [15:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: frame %0d %s mismatch, expected %0d, actual %0d",
                     stamp, frames_checked, name, want_v, got_v);
        end
    endfunction

    // Called for every accepted output transaction.
    function void check_frame(ctfp_pkg::result_t got, time stamp);
        ctfp_pkg::result_t want;
        if (awaited.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual ok=%0b x=%0d y=%0d cmd=%0d",
                     stamp, got.ok, got.x, got.y, got.cmd);
            return;
        end
        want = awaited.pop_front();
        match_field("frame_ok", stamp, {15'd0, want.ok}, {15'd0, got.ok});
        match_field("offset_x", stamp, want.x, got.x);
        match_field("offset_y", stamp, want.y, got.y);
        match_field("command_echo", stamp, want.cmd, got.cmd);
        frames_checked++;
    endfunction
endclass

module tb_csv_three_int_frame_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Run shape
    localparam int unsigned BYTE_TARGET  = 1950;  // stop offering new frames past this
    localparam int unsigned IDLE_PCT     = 23;    // chance of an idle cycle, both sides
    localparam int unsigned CALM_TX_FROM = 1000;  // sender never idles in this byte window
    localparam int unsigned CALM_TX_TO   = 1300;
    localparam int unsigned CALM_RX_FROM = 1500;  // receiver never stalls in this cycle window
    localparam int unsigned CALM_RX_TO   = 2000;
    localparam int unsigned PRESSURE_AT  = 300;   // byte count that starts the long hold-off
    localparam int unsigned HOLD_CYCLES  = 250;
    localparam int unsigned DRAIN_CYCLES = 20;    // idle time after the last expected result, to catch extra results
    localparam int unsigned TIMEOUT_NS   = 2_000_000;

    typedef enum int unsigned {SIGN_NONE, SIGN_PLUS, SIGN_MINUS} sign_style_t;
    typedef enum int unsigned {MUT_OVERWRITE, MUT_TRUNCATE, MUT_STRAY_SIGN, MUT_DELIM} mutation_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte   = 8'd0;
    logic               frame_end = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               frame_ok;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] command_echo;

    frame_result_tracker tracker;
    logic [7:0]          frame_q[$];      // bytes of the frame being built
    int unsigned         bytes_sent = 0;
    bit                  pressure_req = 1'b0;

    csv_three_int_frame_parser_unit u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_ok     (frame_ok),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .command_echo (command_echo)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Monitor. Everything is driven on the rising edge, so the values seen at
    // the falling edge are exactly what the next rising edge will act on.
    always @(negedge clk)
    begin
        ctfp_pkg::result_t got;
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                tracker.note_byte(rx_byte, frame_end);
            if (out_valid && !out_stall)
            begin
                got.ok  = frame_ok;
                got.x   = offset_x;
                got.y   = offset_y;
                got.cmd = command_echo;
                tracker.check_frame(got, $time);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Frame building
    // ---------------------------------------------------------------------

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            frame_q.push_back(s[i]);
    endfunction

    // Mostly in-range values, with the limits and a tail of overflows.
    function automatic int unsigned pick_magnitude();
        case ($urandom_range(9))
            0, 1, 2: return $urandom_range(9);
            3, 4, 5: return $urandom_range(999);
            6, 7:    return $urandom_range(32768);
            8:       return 32766 + $urandom_range(3);    // around the limit
            default: return $urandom_range(99999, 32770); // overflow
        endcase
    endfunction

    function automatic void push_number(sign_style_t s, int unsigned value);
        logic [7:0]  digits[$];
        int unsigned m;
        m = value;
        if (s == SIGN_PLUS)
            frame_q.push_back(ctfp_pkg::CHAR_PLUS);
        else if (s == SIGN_MINUS)
            frame_q.push_back(ctfp_pkg::CHAR_MINUS);
        if ($urandom_range(9) == 0)
            frame_q.push_back(ctfp_pkg::CHAR_ZERO);   // leading zero
        do
        begin
            digits.push_front(ctfp_pkg::CHAR_ZERO + 8'(m % 10));
            m = m / 10;
        end
        while (m != 0);
        foreach (digits[i])
            frame_q.push_back(digits[i]);
    endfunction

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(2))
            0:       return ctfp_pkg::CHAR_COMMA;
            1:       return ctfp_pkg::CHAR_CR;
            default: return ctfp_pkg::CHAR_LF;
        endcase
    endfunction

    // Characters the parser actually reacts to.
    function automatic logic [7:0] pick_parse_char();
        case ($urandom_range(3))
            0:       return ctfp_pkg::CHAR_ZERO + 8'($urandom_range(9));
            1:       return pick_delim();
            2:       return ctfp_pkg::CHAR_PLUS;
            default: return ctfp_pkg::CHAR_MINUS;
        endcase
    endfunction

    function automatic void build_good_frame();
        frame_q.delete();
        for (int f = 0; f < 3; f++)
        begin
            push_number(sign_style_t'($urandom_range(2)), pick_magnitude());
            if (f < 2)
                frame_q.push_back(ctfp_pkg::CHAR_COMMA);
        end
        // third field ends at frame end, CR, LF or CR LF
        case ($urandom_range(3))
            0: ;
            1: frame_q.push_back(ctfp_pkg::CHAR_CR);
            2: frame_q.push_back(ctfp_pkg::CHAR_LF);
            default:
            begin
                frame_q.push_back(ctfp_pkg::CHAR_CR);
                frame_q.push_back(ctfp_pkg::CHAR_LF);
            end
        endcase
        // trailing bytes, ignored by the parser once the third field has ended with CR or LF
        repeat ($urandom_range(2))
            frame_q.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void build_broken_frame();
        int unsigned pos;
        build_good_frame();
        pos = $urandom_range(frame_q.size() - 1);
        case (mutation_t'($urandom_range(3)))
            MUT_OVERWRITE:  frame_q[pos] = 8'($urandom_range(255));
            MUT_TRUNCATE:
                while (frame_q.size() > pos + 1)
                    frame_q.pop_back();
            MUT_STRAY_SIGN: frame_q.insert(pos, $urandom_range(1) ? ctfp_pkg::CHAR_PLUS
                                                                  : ctfp_pkg::CHAR_MINUS);
            default:        frame_q[pos] = pick_delim();
        endcase
    endfunction

    function automatic void build_noise_frame();
        frame_q.delete();
        repeat ($urandom_range(6, 1))
            frame_q.push_back($urandom_range(1) ? 8'($urandom_range(255)) : pick_parse_char());
    endfunction

    // ---------------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------------

    // Offer one byte and hold it until the block takes it.
    task automatic offer_byte(input logic [7:0] b, input logic last);
        bit taken;
        if (bytes_sent < CALM_TX_FROM || bytes_sent >= CALM_TX_TO)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        frame_end <= last;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        bytes_sent++;
        if (bytes_sent == PRESSURE_AT)
            pressure_req = 1'b1;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            offer_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    // Receiver: random stalls, one long hold-off to back the block up into
    // its input, and a stretch with no stalls at all.
    initial
    begin
        int unsigned cyc;
        int unsigned hold_left;
        bit          pressure_served;
        cyc             = 0;
        hold_left       = 0;
        pressure_served = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (pressure_req && !pressure_served)
            begin
                pressure_served = 1'b1;
                hold_left       = HOLD_CYCLES - 1;
                out_stall       <= 1'b1;
            end
            else if (cyc >= CALM_RX_FROM && cyc < CALM_RX_TO)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned kind;
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: both range limits, both signs, CR ending with a byte after
        // the third field.
        push_text("-32768,32767,+0");
        frame_q.push_back(ctfp_pkg::CHAR_CR);
        push_text("x");
        send_frame();
        // one-byte frame ending inside the x field: x written, frame fails
        push_text("7");
        send_frame();
        // overflow of a positive field: x keeps its old value
        push_text("32768,");
        send_frame();
        // second sign is not allowed
        push_text("+-1");
        send_frame();
        // x field ended by LF instead of comma: x written, frame fails
        push_text("9");
        frame_q.push_back(ctfp_pkg::CHAR_LF);
        send_frame();

        // Random: mostly well-formed frames with random contents
        while (bytes_sent < BYTE_TARGET)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
                build_good_frame();
            else if (kind < 88)
                build_broken_frame();
            else
                build_noise_frame();
            send_frame();
        end
        in_valid <= 1'b0;

        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end
endmodule

/* sim.f */
src/ctfp_pkg.sv
src/ctfp_parser.sv
src/csv_three_int_frame_parser_unit.sv
tb/tb_csv_three_int_frame_parser_unit.sv
